// ===== rtl/core/kcst_pkg.sv =====
// kcst_pkg: shared widths, command codes, controller states and the
// command/status structs between the keyed count/sum table controller and datapath.
// no dependencies
package kcst_pkg;

    localparam int KEY_W               = 31;
    localparam int RATING_W            = 16;
    localparam int FIRST_W             = 16;
    localparam int COUNT_W             = 32;
    localparam int SUM_W               = 48;
    localparam int IN_DATA_W           = 64;
    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    typedef enum logic {
        CMD_ACCUMULATE = 1'b0,
        CMD_SEARCH     = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/kcst_ctrl.sv =====
// kcst_ctrl: sequencer for the keyed count/sum table, steps each word
// through accept, entry scan and update. depends on kcst_pkg
module kcst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  kcst_pkg::dp_status_t status,
    output kcst_pkg::ctrl_cmd_t  cmd
);
    import kcst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.hit || status.miss)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.update = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_UPDATE:
            begin
                // hold the update until the output register can take the result
                cmd.update = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/kcst_datapath.sv =====
// kcst_datapath: entry memory, scan counter, key compare, saturating update
// and output register of the keyed count/sum table. depends on kcst_pkg
module kcst_datapath #(
    parameter int TABLE_DEPTH = kcst_pkg::DEFAULT_TABLE_DEPTH,
    parameter int USED_W      = $clog2(TABLE_DEPTH + 1),
    parameter int OUT_DATA_W  = ((kcst_pkg::COUNT_W + kcst_pkg::SUM_W + USED_W + 2 + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [kcst_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  kcst_pkg::ctrl_cmd_t            cmd,
    output kcst_pkg::dp_status_t           status,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [OUT_DATA_W-1:0]          m_tdata
);
    import kcst_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } entry_t;

    entry_t mem [TABLE_DEPTH];

    // item being worked on
    command_t            command_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [RATING_W-1:0] rating_reg;
    logic [FIRST_W-1:0]  first_reg;

    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;
    logic [USED_W-1:0] idx_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic              rd_pend_reg;
    logic              hit_reg;
    entry_t            rd_data_reg;

    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    logic               found_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [USED_W-1:0]  out_used_reg;
    logic               full_reg;
    logic               out_valid_reg;

    logic               found_next;
    logic [COUNT_W-1:0] count_next;
    logic [SUM_W-1:0]   sum_next;
    logic               full_next;

    logic               key_match;
    logic               has_room;
    logic [COUNT_W-1:0] count_inc;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;

    assign key_match       = rd_pend_reg && (rd_data_reg.key == key_reg);
    assign status.hit      = cmd.scan && key_match;
    assign status.miss     = cmd.scan && !rd_pend_reg && (idx_reg == used_reg);
    assign status.out_free = !out_valid_reg || m_tready;

    // one read per cycle, stop issuing once the key is seen
    assign rd_en = cmd.scan && !key_match && (idx_reg < used_reg);

    assign has_room  = used_reg < USED_W'(TABLE_DEPTH);
    assign count_inc = (rd_data_reg.count == COUNT_MAX) ? rd_data_reg.count
                                                        : rd_data_reg.count + 1'b1;
    assign sum_add   = {1'b0, rd_data_reg.sum} + (SUM_W + 1)'(rating_reg);
    assign sum_sat   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    always_comb
    begin
        found_next = hit_reg;
        count_next = '0;
        sum_next   = '0;
        full_next  = 1'b0;
        used_next  = used_reg;
        wr_en      = 1'b0;
        wr_addr    = rd_idx_reg;
        wr_data    = rd_data_reg;
        if (hit_reg)
        begin
            count_next = rd_data_reg.count;
            sum_next   = rd_data_reg.sum;
            if (command_reg == CMD_ACCUMULATE)
            begin
                count_next    = count_inc;
                sum_next      = sum_sat;
                wr_en         = cmd.update;
                wr_data.count = count_inc;
                wr_data.sum   = sum_sat;
            end
        end
        else if (command_reg == CMD_ACCUMULATE)
        begin
            if (has_room)
            begin
                count_next    = COUNT_W'(first_reg);
                sum_next      = SUM_W'(rating_reg);
                used_next     = used_reg + 1'b1;
                wr_en         = cmd.update;
                wr_addr       = used_reg[ADDR_W-1:0];
                wr_data.key   = key_reg;
                wr_data.count = COUNT_W'(first_reg);
                wr_data.sum   = SUM_W'(rating_reg);
            end
            else
            begin
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
            rd_idx_reg  <= idx_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= command_t'(s_tuser);
            key_reg     <= s_tdata[KEY_W-1:0];
            rating_reg  <= s_tdata[KEY_W+RATING_W-1:KEY_W];
            first_reg   <= s_tdata[KEY_W+RATING_W+FIRST_W-1:KEY_W+RATING_W];
        end
        if (cmd.update)
        begin
            found_reg    <= found_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            out_used_reg <= used_next;
            full_reg     <= full_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg     <= '0;
                rd_pend_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_pend_reg <= rd_en;
                if (rd_en)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (key_match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.update)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({full_reg, out_used_reg, sum_reg, count_reg, found_reg});

endmodule

// ===== rtl/core/keyed_count_sum_table.sv =====
// keyed_count_sum_table: a group-by table that keeps one entry per key with an
// occurrence count and a saturating fixed point sum, in insertion order.
// Each word scans the entries in use one per cycle through the single read port
// of the entry memory, oldest first. A word whose key sits at entry i stops after
// reading entries 0 through i; a key that is absent reads all N entries in use,
// at most TABLE_DEPTH. A finished result waits in the output register
// while the next word is already taken. The entry memory needs no clearing after
// reset: only entries below the fill count are ever read.
// depends on kcst_pkg, kcst_ctrl, kcst_datapath
module keyed_count_sum_table #(
    parameter int TABLE_DEPTH = kcst_pkg::DEFAULT_TABLE_DEPTH,
    parameter int USED_W      = $clog2(TABLE_DEPTH + 1),
    parameter int OUT_DATA_W  = ((kcst_pkg::COUNT_W + kcst_pkg::SUM_W + USED_W + 2 + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // item_key, rating, first_count, zero pad
    input  logic [kcst_pkg::IN_DATA_W-1:0] s_tdata,
    // command
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found, entry_count, entry_sum, entries_used, table_full, zero pad
    output logic [OUT_DATA_W-1:0]          m_tdata
);
    import kcst_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    kcst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kcst_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .USED_W      (USED_W),
        .OUT_DATA_W  (OUT_DATA_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
